@@ hw/rtl/look_at_view_matrix_macros.svh @@
// ---------------------------------------------------------------------------
// Look-at view matrix: assertion macros
// Concurrent assertion wrappers, sampled on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define LAV_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lav: assertion failed");

// next-cycle implication
`define LAV_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lav: assertion failed");

`else

`define LAV_ASSERT_IMP(label, ante, cons)
`define LAV_ASSERT_NXT(label, ante, cons)

`endif

`endif

@@ hw/rtl/lav_pkg.sv @@
// ---------------------------------------------------------------------------
// Look-at view matrix: shared package
// Stream widths and the item type passed from the front end to the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lav_pkg;

    localparam int IN_W    = 288;   // nine 32-bit fields
    localparam int OUT_W   = 128;   // four 32-bit columns
    localparam int USER_W  = 3;     // row index and degenerate flag
    localparam int Q_DEPTH = 2;     // front-to-back queue entries
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One camera setup, with eye minus target already formed
    typedef struct packed {
        logic [2:0][31:0] eye;
        logic [2:0][32:0] diff;
        logic [2:0][31:0] up;
        logic             dzero;   // eye equals target
    } lav_item_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic      valid;
        lav_item_t item;
    } lav_head_t;

endpackage

@@ hw/rtl/lav_front.sv @@
// ---------------------------------------------------------------------------
// Look-at view matrix: front end
// Accepts items, forms eye minus target, flags a zero direction and queues.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lav_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [lav_pkg::IN_W-1:0] s_tdata,
    output lav_pkg::lav_head_t      head,
    input  logic                    pop
);
    import lav_pkg::*;

    lav_item_t              entry_mem [Q_DEPTH];
    lav_item_t              item_in;
    logic [Q_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]     count_reg, count_next;
    logic                   push;
    logic [32:0]            diff [3];

    // unpack the item and form the direction before normalisation
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = {s_tdata[32*i+31], s_tdata[32*i +: 32]}
                    - {s_tdata[96+32*i+31], s_tdata[96+32*i +: 32]};
            item_in.eye[i]  = s_tdata[32*i +: 32];
            item_in.diff[i] = diff[i];
            item_in.up[i]   = s_tdata[192+32*i +: 32];
        end
        item_in.dzero = (diff[0] == 33'd0) && (diff[1] == 33'd0) && (diff[2] == 33'd0);
    end

    assign s_tready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign push     = s_tvalid && s_tready;

    // queue pointers
    always_comb
    begin
        wr_ptr_next = push ? Q_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? Q_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= item_in;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = entry_mem[rd_ptr_reg];

endmodule

@@ hw/rtl/lav_isqrt.sv @@
// ---------------------------------------------------------------------------
// Look-at view matrix: integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lav_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    localparam int STEPS = 32;
    localparam int CNT_W = $clog2(STEPS);

    logic [63:0]      n_reg, n_next;
    logic [63:0]      res_reg, res_next;
    logic [63:0]      bit_reg, bit_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [63:0]      trial;

    // one digit-pair step of the restoring square root
    always_comb
    begin
        n_next    = n_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = res_reg + bit_reg;
        if (start)
        begin
            n_next    = radicand;
            res_next  = '0;
            bit_next  = 64'd1 << 62;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (n_reg >= trial)
            begin
                n_next   = n_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

@@ hw/rtl/lav_div.sv @@
// ---------------------------------------------------------------------------
// Look-at view matrix: component divider
// Rounded |c| * 2^FRAC_BITS / length, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lav_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [29:0]          mag,
    input  logic [31:0]          len,
    output logic                 done,
    output logic [FRAC_BITS:0]   quo
);
    localparam int NUM_W = 31 + FRAC_BITS;
    localparam int Q_W   = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(Q_W);

    logic [NUM_W-1:0] num;
    logic [31:0]      rem_reg, rem_next;
    logic [Q_W-1:0]   lo_reg, lo_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [32:0]      trial;
    logic             ge;

    // numerator with half the divisor added for rounding
    assign num   = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(len[31:1]);
    assign trial = {rem_reg, lo_reg[Q_W-1]};
    assign ge    = (trial >= {1'b0, len});

    // restoring long division; quotient is at most 2^FRAC_BITS
    always_comb
    begin
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = 32'(num[NUM_W-1:Q_W]);
            lo_next   = num[Q_W-1:0];
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 32'(trial - {1'b0, len}) : trial[31:0];
            lo_next  = {lo_reg[Q_W-2:0], 1'b0};
            q_next   = {q_reg[Q_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(Q_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

@@ hw/rtl/lav_back.sv @@
// ---------------------------------------------------------------------------
// Look-at view matrix: back end
// Sequencer over a shared multiplier, square root and dividers; builds the
// three basis vectors and translations, then emits four rows.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "look_at_view_matrix_macros.svh"

module lav_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lav_pkg::lav_head_t        head,
    output logic                      pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [lav_pkg::OUT_W-1:0] m_tdata,
    output logic [lav_pkg::USER_W-1:0] m_tuser,
    output logic                      m_tlast
);
    import lav_pkg::*;

    localparam int RC_W = FRAC_BITS + 2;
    localparam int Q_W  = FRAC_BITS + 1;
    localparam logic [31:0] ONE_Q = 32'd1 << FRAC_BITS;
    localparam logic [63:0] HALF  = 64'd1 << (FRAC_BITS - 1);

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_MAG     = 14'b00000000000010,
        S_SHIFT   = 14'b00000000000100,
        S_SQ      = 14'b00000000001000,
        S_ROOT_GO = 14'b00000000010000,
        S_ROOT    = 14'b00000000100000,
        S_DIV_GO  = 14'b00000001000000,
        S_DIV     = 14'b00000010000000,
        S_NEXT    = 14'b00000100000000,
        S_CROSS   = 14'b00001000000000,
        S_XFER    = 14'b00010000000000,
        S_DOT     = 14'b00100000000000,
        S_TRANS   = 14'b01000000000000,
        S_OUT     = 14'b10000000000000
    } state_t;

    // vector being normalised: 0 right, 1 camera up, 2 direction
    localparam logic [1:0] V_RIGHT = 2'd0;
    localparam logic [1:0] V_UP    = 2'd1;
    localparam logic [1:0] V_DIR   = 2'd2;
    localparam logic [1:0] LAST_ROW = 2'd3;

    state_t            state_reg, state_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [1:0]        nsel_reg, nsel_next;
    logic              bad_reg, bad_next;
    logic [31:0]       eye_reg [3], eye_next [3];
    logic [31:0]       up_reg [3], up_next [3];
    logic [63:0]       vec_reg [3], vec_next [3];
    logic              vneg_reg [3], vneg_next [3];
    logic [63:0]       mag_reg [3], mag_next [3];
    logic [RC_W-1:0]   rows_reg [3][3], rows_next [3][3];
    logic [63:0]       acc_reg [3], acc_next [3];
    logic [31:0]       tr_reg [3], tr_next [3];
    logic signed [65:0] prod_reg, prod_next;
    logic              pv_reg, pv_next;
    logic [1:0]        pidx_reg, pidx_next;
    logic              pneg_reg, pneg_next;
    logic [1:0]        out_row_reg, out_row_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;
    logic [USER_W-1:0] out_user_reg, out_user_next;
    logic              out_last_reg, out_last_next;

    logic              clr;
    logic              out_load;
    logic              mul_en;
    logic signed [32:0] mul_a, mul_b;
    logic [1:0]        mul_idx;
    logic              mul_neg;
    logic [63:0]       mor;
    logic              vec_zero;
    logic [63:0]       p64;
    logic              root_start, root_done;
    logic [31:0]       root;
    logic              div_start;
    logic [2:0]        div_done;
    logic [Q_W-1:0]    div_q [3];
    logic [1:0]        ai, bi, dr, dc;

    // operand order of the cross product, two products per component
    function automatic logic [1:0] cross_ai(input logic [2:0] k);
        case (k)
            3'd0:    return 2'd1;
            3'd1:    return 2'd2;
            3'd2:    return 2'd2;
            3'd3:    return 2'd0;
            3'd4:    return 2'd0;
            3'd5:    return 2'd1;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] cross_bi(input logic [2:0] k);
        case (k)
            3'd0:    return 2'd2;
            3'd1:    return 2'd1;
            3'd2:    return 2'd0;
            3'd3:    return 2'd2;
            3'd4:    return 2'd1;
            3'd5:    return 2'd0;
            default: return 2'd0;
        endcase
    endfunction

    // dot product walk: row and column of each of the nine products
    function automatic logic [1:0] dot_row(input logic [3:0] c);
        case (c)
            4'd0, 4'd1, 4'd2: return 2'd0;
            4'd3, 4'd4, 4'd5: return 2'd1;
            4'd6, 4'd7, 4'd8: return 2'd2;
            default:          return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] dot_col(input logic [3:0] c);
        case (c)
            4'd0, 4'd3, 4'd6: return 2'd0;
            4'd1, 4'd4, 4'd7: return 2'd1;
            4'd2, 4'd5, 4'd8: return 2'd2;
            default:          return 2'd0;
        endcase
    endfunction

    function automatic logic signed [32:0] sx_rc(input logic [RC_W-1:0] x);
        return {{(33-RC_W){x[RC_W-1]}}, x};
    endfunction

    function automatic logic [31:0] out_rc(input logic [RC_W-1:0] x);
        return {{(32-RC_W){x[RC_W-1]}}, x};
    endfunction

    // round half away from zero, negate and saturate to 32 bits
    function automatic logic [31:0] neg_dot_sat(input logic [63:0] s);
        logic [63:0] m;
        logic [63:0] m2;
        logic [31:0] r;
        m  = s[63] ? (64'd0 - s) : s;
        m2 = (m + HALF) >> FRAC_BITS;
        if (s[63])
        begin
            r = (m2 > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m2[31:0];
        end
        else
        begin
            r = (m2 > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - m2[31:0]);
        end
        return r;
    endfunction

    assign mor      = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign vec_zero = (vec_reg[0] == 64'd0) && (vec_reg[1] == 64'd0) && (vec_reg[2] == 64'd0);
    assign p64      = prod_reg[63:0];
    assign out_load = !out_valid_reg || m_tready;
    assign ai       = cross_ai(cnt_reg[2:0]);
    assign bi       = cross_bi(cnt_reg[2:0]);
    assign dr       = dot_row(cnt_reg);
    assign dc       = dot_col(cnt_reg);

    // shared square root and one divider lane per component
    lav_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (acc_reg[0]),
        .done     (root_done),
        .root     (root)
    );

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        lav_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .start (div_start),
            .mag   (mag_reg[g][29:0]),
            .len   (root),
            .done  (div_done[g]),
            .quo   (div_q[g])
        );
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        nsel_next      = nsel_reg;
        bad_next       = bad_reg;
        eye_next       = eye_reg;
        up_next        = up_reg;
        vec_next       = vec_reg;
        vneg_next      = vneg_reg;
        mag_next       = mag_reg;
        rows_next      = rows_reg;
        tr_next        = tr_reg;
        out_row_next   = out_row_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        clr            = 1'b0;
        root_start     = 1'b0;
        div_start      = 1'b0;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        mul_idx        = 2'd0;
        mul_neg        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        eye_next[i] = head.item.eye[i];
                        up_next[i]  = head.item.up[i];
                        vec_next[i] = {{31{head.item.diff[i][32]}}, head.item.diff[i]};
                    end
                    if (head.item.dzero)
                    begin
                        // the three basis rows and translations collapse to zero
                        for (int k = 0; k < 3; k++)
                        begin
                            tr_next[k] = '0;
                            for (int i = 0; i < 3; i++)
                            begin
                                rows_next[k][i] = '0;
                            end
                        end
                        bad_next     = 1'b1;
                        out_row_next = 2'd0;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        bad_next   = 1'b0;
                        nsel_next  = V_DIR;
                        state_next = S_MAG;
                    end
                end
            end

            S_MAG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    vneg_next[i] = vec_reg[i][63];
                    mag_next[i]  = vec_reg[i][63] ? (64'd0 - vec_reg[i]) : vec_reg[i];
                end
                if (vec_zero)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        rows_next[nsel_reg][i] = '0;
                    end
                    bad_next   = 1'b1;
                    state_next = S_NEXT;
                end
                else
                begin
                    state_next = S_SHIFT;
                end
            end

            // bring the largest magnitude into [2^29, 2^30)
            S_SHIFT:
            begin
                if (|mor[63:38])
                begin
                    for (int i = 0; i < 3; i++) mag_next[i] = mag_reg[i] >> 8;
                end
                else if (|mor[63:30])
                begin
                    for (int i = 0; i < 3; i++) mag_next[i] = mag_reg[i] >> 1;
                end
                else if (!mor[29])
                begin
                    if (!(|mor[63:21]))
                    begin
                        for (int i = 0; i < 3; i++) mag_next[i] = mag_reg[i] << 8;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++) mag_next[i] = mag_reg[i] << 1;
                    end
                end
                else
                begin
                    clr        = 1'b1;
                    cnt_next   = 4'd0;
                    state_next = S_SQ;
                end
            end

            // sum of squares into accumulator 0
            S_SQ:
            begin
                if (cnt_reg < 4'd3)
                begin
                    mul_en = 1'b1;
                    mul_a  = {3'b000, mag_reg[cnt_reg[1:0]][29:0]};
                    mul_b  = {3'b000, mag_reg[cnt_reg[1:0]][29:0]};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd3)
                begin
                    state_next = S_ROOT_GO;
                end
            end

            S_ROOT_GO:
            begin
                root_start = 1'b1;
                state_next = S_ROOT;
            end

            S_ROOT:
            begin
                if (root_done)
                begin
                    state_next = S_DIV_GO;
                end
            end

            S_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                if (div_done[0])
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        rows_next[nsel_reg][i] = vneg_reg[i]
                            ? ({RC_W{1'b0}} - {1'b0, div_q[i]}) : {1'b0, div_q[i]};
                    end
                    state_next = S_NEXT;
                end
            end

            S_NEXT:
            begin
                clr        = 1'b1;
                cnt_next   = 4'd0;
                state_next = (nsel_reg == V_UP) ? S_DOT : S_CROSS;
            end

            // up x dir, then dir x right
            S_CROSS:
            begin
                if (cnt_reg < 4'd6)
                begin
                    mul_en  = 1'b1;
                    mul_idx = cnt_reg[2:1];
                    mul_neg = cnt_reg[0];
                    if (nsel_reg == V_DIR)
                    begin
                        mul_a = {up_reg[ai][31], up_reg[ai]};
                        mul_b = sx_rc(rows_reg[V_DIR][bi]);
                    end
                    else
                    begin
                        mul_a = sx_rc(rows_reg[V_DIR][ai]);
                        mul_b = sx_rc(rows_reg[V_RIGHT][bi]);
                    end
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd6)
                begin
                    state_next = S_XFER;
                end
            end

            S_XFER:
            begin
                for (int i = 0; i < 3; i++) vec_next[i] = acc_reg[i];
                nsel_next  = (nsel_reg == V_DIR) ? V_RIGHT : V_UP;
                state_next = S_MAG;
            end

            // row . eye for the three basis rows
            S_DOT:
            begin
                if (cnt_reg < 4'd9)
                begin
                    mul_en  = 1'b1;
                    mul_idx = dr;
                    mul_a   = sx_rc(rows_reg[dr][dc]);
                    mul_b   = {eye_reg[dc][31], eye_reg[dc]};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd9)
                begin
                    state_next = S_TRANS;
                end
            end

            S_TRANS:
            begin
                for (int k = 0; k < 3; k++) tr_next[k] = neg_dot_sat(acc_reg[k]);
                out_row_next = 2'd0;
                state_next   = S_OUT;
            end

            S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_user_next  = {bad_reg, out_row_reg};
                    out_last_next  = (out_row_reg == LAST_ROW);
                    if (out_row_reg == LAST_ROW)
                    begin
                        out_data_next = {ONE_Q, 96'd0};
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        out_data_next = {tr_reg[out_row_reg],
                                         out_rc(rows_reg[out_row_reg][2]),
                                         out_rc(rows_reg[out_row_reg][1]),
                                         out_rc(rows_reg[out_row_reg][0])};
                        out_row_next  = out_row_reg + 2'd1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // product register and accumulators
    always_comb
    begin
        prod_next = mul_a * mul_b;
        pv_next   = mul_en;
        pidx_next = mul_idx;
        pneg_next = mul_neg;
        acc_next  = acc_reg;
        if (clr)
        begin
            for (int i = 0; i < 3; i++) acc_next[i] = '0;
        end
        else if (pv_reg)
        begin
            acc_next[pidx_reg] = acc_reg[pidx_reg] + (pneg_reg ? (64'd0 - p64) : p64);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        nsel_reg     <= nsel_next;
        bad_reg      <= bad_next;
        eye_reg      <= eye_next;
        up_reg       <= up_next;
        vec_reg      <= vec_next;
        vneg_reg     <= vneg_next;
        mag_reg      <= mag_next;
        rows_reg     <= rows_next;
        acc_reg      <= acc_next;
        tr_reg       <= tr_next;
        prod_reg     <= prod_next;
        pidx_reg     <= pidx_next;
        pneg_reg     <= pneg_next;
        out_row_reg  <= out_row_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // unit completions line up with the waiting states
    `LAV_ASSERT_IMP(a_root_done_state, root_done, state_reg == S_ROOT)
    `LAV_ASSERT_IMP(a_div_done_state, div_done[0], state_reg == S_DIV)
    // no product is in flight once the sequencer is back at rest
    `LAV_ASSERT_IMP(a_idle_no_product, state_reg == S_IDLE, !pv_reg)
    // the final row hands control back to the queue
    `LAV_ASSERT_NXT(a_last_row_idle, (state_reg == S_OUT) && out_load && (out_row_reg == LAST_ROW), state_reg == S_IDLE)

endmodule

@@ hw/rtl/look_at_view_matrix.sv @@
// ---------------------------------------------------------------------------
// Look-at view matrix
// Camera setup in, 4x4 view matrix out as four rows, Q16.16 by default.
// ---------------------------------------------------------------------------
//  channel  | dir | tdata                           | tuser             | tlast
//  s_axis   | in  | eye xyz, target xyz, up xyz     | -                 | -
//  m_axis   | out | col0, col1, col2, col3          | row_index, degen. | last_row
//
//  Each item runs through the shared 32-step square root and the bit-serial
//  dividers (FRAC_BITS+1 quotient bits, 17 at Q16.16) once per normalisation,
//  after the alignment shift steps; eye equal to target skips straight to the
//  output rows. A two-entry queue keeps taking items while the back
//  end works; the output register holds a row while the receiver stalls,
//  and the sequencer waits on it, so with ready high a row leaves each cycle.
//  Reset clears the queue, the sequencer and the output valid.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module look_at_view_matrix #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [lav_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // col0, col1, col2, col3
    output logic [lav_pkg::OUT_W-1:0]  m_tdata,
    // row_index[1:0], degenerate
    output logic [lav_pkg::USER_W-1:0] m_tuser,
    output logic                       m_tlast
);
    import lav_pkg::*;

    lav_head_t head;
    logic      pop;

    lav_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .head     (head),
        .pop      (pop)
    );

    lav_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ tb/look_at_view_matrix_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Look-at view matrix: testbench
// Drives camera setups into the stream input and checks each matrix row
// against a fixed-point predictor of the normalise / cross / dot chain.
// Both sides idle at random; one long output hold-off fills the block.
// ---------------------------------------------------------------------------

module look_at_view_matrix_test;

    localparam int FRAC      = 16;
    localparam int CYC_LIMIT = 2000000;
    localparam int TAIL_CYC  = 600;

    typedef longint vec3_t [3];

    typedef struct packed {
        logic [1:0]  row_index;
        logic [31:0] col0;
        logic [31:0] col1;
        logic [31:0] col2;
        logic [31:0] col3;
        logic        degenerate;
        logic        last_row;
    } matrix_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [lav_pkg::IN_W-1:0]    s_tdata;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [lav_pkg::OUT_W-1:0]   m_tdata;
    logic [lav_pkg::USER_W-1:0]  m_tuser;
    logic                        m_tlast;

    matrix_row_t expected_rows[$];
    int          fail_count;
    int          cycle_count;
    int          hold_cycles;      // pending long hold-off on the output
    bit          out_random;       // output ready idles at random when set
    bit          in_random;        // input gaps inserted when set

    look_at_view_matrix #(.FRAC_BITS(FRAC)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYC_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Unit vector; returns 0 on a zero-length input
    function automatic bit unit_vec(input vec3_t v, output vec3_t o);
        logic [63:0] m [3];
        logic [63:0] mx;
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        int          sh;
        mx = 0;
        sum = 0;
        sh = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (v[i] < 0) ? -v[i] : v[i];
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
        begin
            o[0] = 0; o[1] = 0; o[2] = 0;
            return 1'b0;
        end
        while (mx >= (64'd1 << 30))
        begin
            mx = mx >> 1;
            sh++;
        end
        while (mx < (64'd1 << 29))
        begin
            mx = mx << 1;
            sh--;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (sh > 0)
                m[i] = m[i] >> sh;
            else if (sh < 0)
                m[i] = m[i] << (-sh);
            sum = sum + m[i] * m[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << FRAC) + len / 2) / len;
            o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic void cross_prod(input vec3_t a, input vec3_t b, output vec3_t o);
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // -(a . eye), rounded half away from zero, saturated to 32 bits
    function automatic logic [31:0] translation(input vec3_t a, input vec3_t e);
        longint      s;
        logic [63:0] mg;
        longint      r;
        s = a[0] * e[0] + a[1] * e[1] + a[2] * e[2];
        mg = (s < 0) ? -s : s;
        mg = (mg + (64'd1 << (FRAC - 1))) >> FRAC;
        r = (s < 0) ? longint'(mg) : -longint'(mg);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    // Push the four rows expected for one camera setup
    task automatic predict_matrix(input logic [lav_pkg::IN_W-1:0] d);
        vec3_t       eye, diff, up, c;
        vec3_t       basis [3];
        bit          ok;
        matrix_row_t r;
        for (int i = 0; i < 3; i++)
        begin
            eye[i]  = longint'($signed(d[32*i +: 32]));
            diff[i] = eye[i] - longint'($signed(d[32*(3+i) +: 32]));
            up[i]   = longint'($signed(d[32*(6+i) +: 32]));
        end
        ok = unit_vec(diff, basis[2]);
        cross_prod(up, basis[2], c);
        ok = unit_vec(c, basis[0]) && ok;
        cross_prod(basis[2], basis[0], c);
        ok = unit_vec(c, basis[1]) && ok;
        for (int k = 0; k < 3; k++)
        begin
            r.row_index  = k[1:0];
            r.col0       = basis[k][0][31:0];
            r.col1       = basis[k][1][31:0];
            r.col2       = basis[k][2][31:0];
            r.col3       = translation(basis[k], eye);
            r.degenerate = !ok;
            r.last_row   = 1'b0;
            expected_rows.push_back(r);
        end
        r.row_index  = 2'd3;
        r.col0       = 0;
        r.col1       = 0;
        r.col2       = 0;
        r.col3       = 32'd1 << FRAC;
        r.degenerate = !ok;
        r.last_row   = 1'b1;
        expected_rows.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Output side: ready generation and row checking
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready = 1'b0;
            hold_cycles--;
        end
        else if (!out_random)
            m_tready = 1'b1;
        else if ($urandom_range(0, 99) < 3)
        begin
            // occasional long stall
            m_tready = 1'b0;
            hold_cycles = $urandom_range(10, 60);
        end
        else
            m_tready = ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        matrix_row_t want;
        matrix_row_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.col0       = m_tdata[31:0];
            got.col1       = m_tdata[63:32];
            got.col2       = m_tdata[95:64];
            got.col3       = m_tdata[127:96];
            got.row_index  = m_tuser[1:0];
            got.degenerate = m_tuser[2];
            got.last_row   = m_tlast;
            if (expected_rows.size() == 0)
            begin
                $display("%0t: unexpected row, actual %h", $time, got);
                fail_count++;
            end
            else
            begin
                want = expected_rows.pop_front();
                if (got.row_index !== want.row_index)
                    $display("%0t: row_index expected %0d actual %0d",
                             $time, want.row_index, got.row_index);
                if (got.col0 !== want.col0)
                    $display("%0t: col0 expected %h actual %h", $time, want.col0, got.col0);
                if (got.col1 !== want.col1)
                    $display("%0t: col1 expected %h actual %h", $time, want.col1, got.col1);
                if (got.col2 !== want.col2)
                    $display("%0t: col2 expected %h actual %h", $time, want.col2, got.col2);
                if (got.col3 !== want.col3)
                    $display("%0t: col3 expected %h actual %h", $time, want.col3, got.col3);
                if (got.degenerate !== want.degenerate)
                    $display("%0t: degenerate expected %b actual %b",
                             $time, want.degenerate, got.degenerate);
                if (got.last_row !== want.last_row)
                    $display("%0t: last_row expected %b actual %b",
                             $time, want.last_row, got.last_row);
                if (got !== want)
                    fail_count++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offer one setup, wait for acceptance, then an optional gap
    task automatic send_setup(input logic [lav_pkg::IN_W-1:0] d);
        int gap;
        s_tdata  = d;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predict_matrix(d);
        @(negedge clk);
        gap = 0;
        if (in_random)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 2);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    function automatic logic [lav_pkg::IN_W-1:0] pack_setup(
        input logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
        return {uz, uy, ux, tz, ty, tx, ez, ey, ex};
    endfunction

    function automatic logic [31:0] rand_word(input int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
        endcase
    endfunction

    task automatic wait_drained();
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        logic [31:0] one;
        one = 32'd1 << FRAC;
        // ordinary camera looking down -z, up +y
        send_setup(pack_setup(0, 0, 5*one, 0, 0, 0, 0, one, 0));
        send_setup(pack_setup(one, 2*one, 3*one, -one, 0, one, 0, 0, one));
        // field extremes
        send_setup(pack_setup(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_setup(pack_setup(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        send_setup(pack_setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              0, 0, 0, 32'hFFFF_FFFF, 0, 1));
        // translation saturation: large eye, unit axes
        send_setup(pack_setup(32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000,
                              32'h7FFE_0000, 32'h7FFF_0000, 32'h7FFF_0000, 0, one, 0));
        send_setup(pack_setup(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0001, 32'h8000_0000, 32'h8000_0000, 0, 0, one));
        // smallest non-zero direction
        send_setup(pack_setup(1, 0, 0, 0, 0, 0, 0, 1, 0));
        send_setup(pack_setup(0, 0, 0, 0, 0, 1, 1, 1, 1));
    endtask

    task automatic test_degenerate();
        logic [31:0] one;
        one = 32'd1 << FRAC;
        // eye equals target
        send_setup(pack_setup(one, one, one, one, one, one, 0, one, 0));
        send_setup(pack_setup(0, 0, 0, 0, 0, 0, 0, 0, 0));
        // up parallel to view direction
        send_setup(pack_setup(0, 5*one, 0, 0, 0, 0, 0, one, 0));
        send_setup(pack_setup(0, 0, 3*one, 0, 0, one, 0, 0, -2*one));
        // zero up hint, then an up along the view direction at the field extremes
        send_setup(pack_setup(one, 0, 0, 0, 0, 0, 0, 0, 0));
        send_setup(pack_setup(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0));
    endtask

    task automatic test_random(input int count);
        int          mode;
        int          kind;
        logic [31:0] w [9];
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(0, 2);
            kind = $urandom_range(0, 19);
            for (int i = 0; i < 9; i++)
                w[i] = rand_word(mode);
            if (kind == 0)
            begin
                // eye on target
                w[3] = w[0]; w[4] = w[1]; w[5] = w[2];
            end
            else if (kind == 1)
            begin
                // up along the view direction
                w[6] = w[0] - w[3]; w[7] = w[1] - w[4]; w[8] = w[2] - w[5];
            end
            send_setup(pack_setup(w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8]));
        end
    endtask

    // Output held off while setups keep arriving back to back
    task automatic test_backpressure();
        bit prev_in;
        prev_in = in_random;
        in_random = 1'b0;
        hold_cycles = 3000;
        test_random(8);
        in_random = prev_in;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        fail_count  = 0;
        cycle_count = 0;
        hold_cycles = 0;
        out_random  = 1'b0;
        in_random   = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_degenerate();
        in_random  = 1'b1;
        out_random = 1'b1;
        test_random(120);
        test_backpressure();
        out_random = 1'b0;
        in_random  = 1'b0;
        test_random(30);
        in_random  = 1'b1;
        out_random = 1'b1;
        test_random(90);

        s_tvalid = 1'b0;
        wait_drained();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/lav_pkg.sv
hw/rtl/lav_front.sv
hw/rtl/lav_isqrt.sv
hw/rtl/lav_div.sv
hw/rtl/lav_back.sv
hw/rtl/look_at_view_matrix.sv
tb/look_at_view_matrix_test.sv
